// ===== src/hce_pkg.sv =====
// Shared types, codes and defaults for the Huffman encoder and packer.
`default_nettype none
package hce_pkg;

    localparam int SYMBOL_COUNT_DEF = 256;
    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int QUEUE_DEPTH      = 4;

    localparam int CODE_W  = 32;
    localparam int LEN_W   = 6;
    localparam int TOTAL_W = 40;

    // input opcodes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_ERROR = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // commands from front to back
    localparam logic [1:0] CMD_ENCODE = 2'd0;
    localparam logic [1:0] CMD_ERROR  = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [7:0]        symbol;
        logic [CODE_W-1:0] code_value;
        logic [LEN_W-1:0]  code_length;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         data_byte;
        logic               last;
        logic [TOTAL_W-1:0] total_bits;
    } t_result;

    typedef struct packed {
        logic [1:0]        op;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } t_cmd;

endpackage
`default_nettype wire

// ===== src/hce_front.sv =====
// Front end: code table, lookup and command issue.
`default_nettype none
module hce_front #(
    parameter int SYMBOL_COUNT = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  hce_pkg::t_in_item i_in_data,
    output logic              o_cmd_valid,
    output hce_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_full
);
    import hce_pkg::*;

    localparam int SYM_W  = $clog2(SYMBOL_COUNT);
    localparam int WORD_W = CODE_W + LEN_W;

    logic [WORD_W-1:0]       r_mem [SYMBOL_COUNT];
    logic [WORD_W-1:0]       r_rd;
    logic [SYMBOL_COUNT-1:0] r_valid;
    logic                    r_s1_v;
    logic [1:0]              r_s1_op;
    logic                    r_s1_hit;

    logic              accept;
    logic              in_range;
    logic [SYM_W-1:0]  idx;
    logic [LEN_W-1:0]  len_clamp;
    logic [CODE_W-1:0] code_mask;

    assign o_in_ready = !r_s1_v || !i_cmd_full;
    assign accept     = i_in_valid && o_in_ready;
    assign in_range   = {1'b0, i_in_data.symbol} < 9'(SYMBOL_COUNT);
    assign idx        = i_in_data.symbol[SYM_W-1:0];

    always_comb begin
        if (i_in_data.code_length > LEN_W'(MAX_CODE_LEN)) begin
            len_clamp = LEN_W'(MAX_CODE_LEN);
        end else begin
            len_clamp = i_in_data.code_length;
        end
        // shifts of 32 or more give zero, so long codes keep every bit
        code_mask = i_in_data.code_value & ~({CODE_W{1'b1}} << len_clamp);
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in_data.opcode == OP_LOAD && in_range) begin
            r_mem[idx] <= {code_mask, len_clamp};
        end
        if (accept && i_in_data.opcode == OP_ENCODE) begin
            r_rd <= r_mem[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_s1_v   <= 1'b0;
            r_s1_op  <= OP_LOAD;
            r_s1_hit <= 1'b0;
        end else begin
            if (accept && i_in_data.opcode == OP_LOAD && in_range) begin
                r_valid[idx] <= 1'b1;
            end
            if (accept) begin
                r_s1_v   <= (i_in_data.opcode == OP_ENCODE) || (i_in_data.opcode == OP_FLUSH);
                r_s1_op  <= i_in_data.opcode;
                r_s1_hit <= in_range && r_valid[idx];
            end else if (r_s1_v && !i_cmd_full) begin
                r_s1_v <= 1'b0;
            end
        end
    end

    always_comb begin
        o_cmd_valid = r_s1_v;
        o_cmd       = '0;
        if (r_s1_op == OP_FLUSH) begin
            o_cmd.op = CMD_FLUSH;
        end else if (r_s1_hit) begin
            o_cmd.op   = CMD_ENCODE;
            o_cmd.code = r_rd[WORD_W-1:LEN_W];
            o_cmd.len  = r_rd[LEN_W-1:0];
        end else begin
            o_cmd.op = CMD_ERROR;
        end
    end

endmodule
`default_nettype wire

// ===== src/hce_queue.sv =====
// Small command FIFO between front and back.
`default_nettype none
module hce_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hce_pkg::t_cmd i_push_data,
    output logic          o_full,
    output logic          o_valid,
    output hce_pkg::t_cmd o_data,
    input  logic          i_pop
);
    import hce_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/hce_back.sv =====
// Back end: bit packer, running total and output register.
`default_nettype none
module hce_back #(
    parameter int MAX_CODE_LEN = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  hce_pkg::t_cmd    i_cmd,
    output logic             o_cmd_take,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output hce_pkg::t_result o_out_data
);
    import hce_pkg::*;

    localparam int SH_W  = MAX_CODE_LEN + 7;
    localparam int CNT_W = $clog2(SH_W + 1);
    localparam int EXT_W = SH_W + CODE_W;

    // bits waiting to go out, left aligned; bits below r_cnt are zero
    logic [SH_W-1:0]    r_sh;
    logic [CNT_W-1:0]   r_cnt;
    logic [TOTAL_W-1:0] r_total;
    logic               r_act;
    logic [1:0]         r_op;
    logic               r_ov;
    t_result            r_out;

    logic               emit_ok;
    logic               step;
    logic               fin;
    logic               free;
    t_result            res;
    logic [SH_W-1:0]    base_sh;
    logic [CNT_W-1:0]   base_cnt;
    logic [TOTAL_W-1:0] base_total;
    logic [SH_W-1:0]    cur_sh;
    logic [CNT_W-1:0]   cur_cnt;
    logic [TOTAL_W-1:0] cur_total;
    logic [CNT_W-1:0]   rem_cnt;
    logic [CNT_W-1:0]   amt;
    logic [EXT_W-1:0]   placed_ext;
    logic [CNT_W-1:0]   new_cnt;
    logic [TOTAL_W:0]   sum;
    logic [SH_W-1:0]    n_sh;
    logic [CNT_W-1:0]   n_cnt;
    logic [TOTAL_W-1:0] n_total;
    logic               n_act;
    logic [1:0]         n_op;

    assign emit_ok = !r_ov || i_out_ready;
    assign step    = r_act && emit_ok;
    assign rem_cnt = r_cnt - CNT_W'(8);

    // result of the active command and the state left behind by it
    always_comb begin
        res            = '0;
        res.total_bits = r_total;
        fin            = 1'b0;
        base_sh        = r_sh;
        base_cnt       = r_cnt;
        base_total     = r_total;
        unique case (r_op)
            CMD_ENCODE: begin
                res.kind      = KIND_DATA;
                res.data_byte = r_sh[SH_W-1 -: 8];
                res.last      = rem_cnt < CNT_W'(8);
                fin           = res.last;
                base_sh       = r_sh << 8;
                base_cnt      = rem_cnt;
            end
            CMD_ERROR: begin
                res.kind = KIND_ERROR;
                res.last = 1'b1;
                fin      = 1'b1;
            end
            CMD_FLUSH: begin
                if (r_cnt != '0) begin
                    res.kind      = KIND_DATA;
                    res.data_byte = r_sh[SH_W-1 -: 8];
                    base_sh       = '0;
                    base_cnt      = '0;
                end else begin
                    res.kind   = KIND_DONE;
                    res.last   = 1'b1;
                    fin        = 1'b1;
                    base_total = '0;
                end
            end
            default: begin
                fin = 1'b1;
            end
        endcase
    end

    assign cur_sh    = step ? base_sh : r_sh;
    assign cur_cnt   = step ? base_cnt : r_cnt;
    assign cur_total = step ? base_total : r_total;

    assign free       = !r_act || (step && fin);
    assign o_cmd_take = free && i_cmd_valid;

    // new code goes right under the bits already waiting
    assign amt        = CNT_W'(SH_W) - CNT_W'(i_cmd.len) - cur_cnt;
    assign placed_ext = EXT_W'(i_cmd.code) << amt;
    assign new_cnt    = cur_cnt + CNT_W'(i_cmd.len);
    assign sum        = {1'b0, cur_total} + (TOTAL_W + 1)'(i_cmd.len);

    always_comb begin
        n_sh    = cur_sh;
        n_cnt   = cur_cnt;
        n_total = cur_total;
        n_op    = r_op;
        n_act   = r_act && !(step && fin);
        if (o_cmd_take) begin
            n_op  = i_cmd.op;
            n_act = 1'b1;
            if (i_cmd.op == CMD_ENCODE) begin
                n_sh    = cur_sh | placed_ext[SH_W-1:0];
                n_cnt   = new_cnt;
                n_total = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
                n_act   = new_cnt >= CNT_W'(8);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sh    <= '0;
            r_cnt   <= '0;
            r_total <= '0;
            r_act   <= 1'b0;
            r_op    <= CMD_ENCODE;
            r_ov    <= 1'b0;
        end else begin
            r_sh    <= n_sh;
            r_cnt   <= n_cnt;
            r_total <= n_total;
            r_act   <= n_act;
            r_op    <= n_op;
            if (step) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    a_enc_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_act && r_op == CMD_ENCODE) |-> (r_cnt >= CNT_W'(8)))
        else $error("encode active without a full byte");

    a_idle_partial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_act |-> (r_cnt < CNT_W'(8)))
        else $error("idle packer holds a full byte");

    a_flush_partial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_act && r_op == CMD_FLUSH) |-> (r_cnt < CNT_W'(8)))
        else $error("flush with more than a partial byte");

    a_total_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_op == CMD_FLUSH && r_cnt == '0 && !o_cmd_take) |=> (r_total == '0))
        else $error("bit total not cleared after flush");

endmodule
`default_nettype wire

// ===== src/huffman_code_encoder_packer.sv =====
// Top level of the Huffman encoder with MSB-first byte packing.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+------------------------
//  input   | in        | i_in_valid / o_in_ready     | i_in_data  (t_in_item)
//  result  | out       | o_out_valid / i_out_ready   | o_out_data (t_result)
//
// A load or an unused opcode is taken at the input and gives no result. An
// encode gives one result beat per cycle while the output is ready, one per
// full byte (up to four for 32-bit codes); the packer starts the next command
// in the cycle of the previous last beat. Table lookup is registered in the
// front stage ahead of the queue and the packer, and results leave through
// an output register. Reset clears the valid bits, the packer and the queue;
// the table contents stay. Either side may stall; the queue lets the front run on.
`default_nettype none
module huffman_code_encoder_packer #(
    parameter int SYMBOL_COUNT = hce_pkg::SYMBOL_COUNT_DEF,
    parameter int MAX_CODE_LEN = hce_pkg::MAX_CODE_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  hce_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output hce_pkg::t_result  o_out_data
);
    import hce_pkg::*;

    // front to queue
    logic  front_cmd_valid;
    t_cmd  front_cmd;
    logic  queue_full;
    // queue to back
    logic  queue_valid;
    t_cmd  queue_cmd;
    logic  back_take;

    // table storage, lookup, classification of each input beat
    hce_front #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_cmd_valid (front_cmd_valid),
        .o_cmd       (front_cmd),
        .i_cmd_full  (queue_full)
    );

    // decouples lookup from packing so each side stalls on its own
    hce_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (front_cmd_valid),
        .i_push_data (front_cmd),
        .o_full      (queue_full),
        .o_valid     (queue_valid),
        .o_data      (queue_cmd),
        .i_pop       (back_take)
    );

    // bit packer, bit total, result beats
    hce_back #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_take  (back_take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire
